// ===== rtl/vvpu_pkg.sv =====
// shared types, widths and helpers for the velocity verlet particle update core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vvpu_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DVS_W      = DATA_W + 1;
    localparam int DIV_STAGES = PROD_W;
    localparam int LANES      = 3;
    // stage one, divider, kick products, term sums, final sum
    localparam int LANE_LAT   = DIV_STAGES + 4;

    localparam logic [PROD_W-1:0] TERM_CAP = 64'h2000_0000_0000_0000;
    localparam logic [DATA_W-1:0] DT_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] spd;
        logic [PROD_W-1:0]        vprod;
        logic                     fneg;
    } side_t;

    typedef struct packed {
        logic [DATA_W-1:0] pos_upd;
        logic [DATA_W-1:0] spd_upd;
        logic [DATA_W-1:0] pos_pass;
        logic [DATA_W-1:0] spd_pass;
    } lane_out_t;

    typedef struct packed {
        logic valid;
        logic cmd;
        logic zero;
    } ctl_t;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vvpu_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// standalone, no package
`timescale 1ns / 1ps
`default_nettype none

module vvpu_divider #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 33
) (
    input  logic             clk,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient
);

    logic [DVS_W-1:0] rem_reg [DVD_W];
    logic [DVD_W-1:0] dvd_reg [DVD_W];
    logic [DVD_W-1:0] quo_reg [DVD_W];
    logic [DVS_W-1:0] dvs_reg [DVD_W];

    genvar i;
    generate
        for (i = 0; i < DVD_W; i++)
        begin : g_stage
            logic [DVS_W-1:0] rem_in;
            logic [DVD_W-1:0] dvd_in;
            logic [DVD_W-1:0] quo_in;
            logic [DVS_W-1:0] dvs_in;
            logic [DVS_W:0]   r_sh;
            logic             ge;
            logic [DVS_W:0]   r_sub;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign dvd_in = dividend;
                assign quo_in = '0;
                assign dvs_in = divisor;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign dvd_in = dvd_reg[i-1];
                assign quo_in = quo_reg[i-1];
                assign dvs_in = dvs_reg[i-1];
            end

            assign r_sh  = {rem_in, dvd_in[DVD_W-1]};
            assign ge    = (r_sh >= {1'b0, dvs_in});
            assign r_sub = r_sh - {1'b0, dvs_in};

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= ge ? r_sub[DVS_W-1:0] : r_sh[DVS_W-1:0];
                dvd_reg[i] <= {dvd_in[DVD_W-2:0], 1'b0};
                quo_reg[i] <= {quo_in[DVD_W-2:0], ge};
                dvs_reg[i] <= dvs_in;
            end
        end
    endgenerate

    assign quotient = quo_reg[DVD_W-1];

endmodule

`default_nettype wire

// ===== rtl/vvpu_lane.sv =====
// one axis of the particle update: kick quotient, drift terms, saturation
// depends on vvpu_pkg and vvpu_divider
`timescale 1ns / 1ps
`default_nettype none

module vvpu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic [vvpu_pkg::DATA_W-1:0]         time_step,
    input  logic signed [vvpu_pkg::DATA_W-1:0]  position,
    input  logic signed [vvpu_pkg::DATA_W-1:0]  speed,
    input  logic signed [vvpu_pkg::DATA_W-1:0]  frc,
    input  logic [vvpu_pkg::DATA_W-1:0]         mass,
    output vvpu_pkg::lane_out_t                 result
);

    import vvpu_pkg::*;

    localparam int WIDE_W = PROD_W + DATA_W;

    // stage one: magnitudes and first products
    logic              fneg;
    logic [DATA_W-1:0] fmag;
    logic [DATA_W-1:0] vmag;
    logic [PROD_W-1:0] num_reg;
    logic [DVS_W-1:0]  dvs_reg;
    side_t             s1_reg;

    assign fneg = frc[DATA_W-1];
    assign fmag = fneg ? (~frc + 1'b1) : frc;
    assign vmag = speed[DATA_W-1] ? (~speed + 1'b1) : speed;

    always_ff @(posedge clk)
    begin
        num_reg      <= PROD_W'(time_step) * PROD_W'(fmag);
        dvs_reg      <= {mass, 1'b0};
        s1_reg.pos   <= position;
        s1_reg.spd   <= speed;
        s1_reg.vprod <= PROD_W'(time_step) * PROD_W'(vmag);
        s1_reg.fneg  <= fneg;
    end

    // dk = dt*|F| / 2m
    logic [PROD_W-1:0] dk;

    vvpu_divider #(
        .DVD_W(PROD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .clk     (clk),
        .dividend(num_reg),
        .divisor (dvs_reg),
        .quotient(dk)
    );

    side_t side_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s1_reg;
        for (int k = 1; k < DIV_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // kick products and speed result
    side_t                    sd;
    logic [PROD_W-1:0]        kmag;
    logic signed [PROD_W-1:0] kick;
    logic signed [PROD_W-1:0] spd_sum;
    logic [PROD_W-1:0]        plo_reg;
    logic [PROD_W-1:0]        phi_reg;
    logic [DATA_W-1:0]        spd_upd2_reg;
    side_t                    s2_reg;

    assign sd      = side_reg[DIV_STAGES-1];
    assign kmag    = (dk > TERM_CAP) ? TERM_CAP : dk;
    assign kick    = sd.fneg ? -$signed(kmag) : $signed(kmag);
    assign spd_sum = PROD_W'(sd.spd) + kick;

    always_ff @(posedge clk)
    begin
        plo_reg      <= PROD_W'(time_step) * PROD_W'(dk[DATA_W-1:0]);
        phi_reg      <= PROD_W'(time_step) * PROD_W'(dk[PROD_W-1:DATA_W]);
        spd_upd2_reg <= sat32(spd_sum);
        s2_reg       <= sd;
    end

    // drift terms
    logic [WIDE_W-1:0]        fprod;
    logic [WIDE_W-1:0]        fsh;
    logic [PROD_W-1:0]        tf_mag;
    logic [PROD_W-1:0]        vsh;
    logic [PROD_W-1:0]        tv_mag;
    logic signed [PROD_W-1:0] tv;
    logic signed [PROD_W-1:0] tf_reg;
    logic signed [PROD_W-1:0] tvpos_reg;
    logic [DATA_W-1:0]        spd_upd3_reg;
    logic [DATA_W-1:0]        pos3_reg;
    logic [DATA_W-1:0]        spd3_reg;

    assign fprod  = WIDE_W'(plo_reg) + {phi_reg, {DATA_W{1'b0}}};
    assign fsh    = fprod >> FRAC_BITS;
    assign tf_mag = (fsh > WIDE_W'(TERM_CAP)) ? TERM_CAP : fsh[PROD_W-1:0];
    assign vsh    = s2_reg.vprod >> FRAC_BITS;
    assign tv_mag = (vsh > TERM_CAP) ? TERM_CAP : vsh;
    assign tv     = s2_reg.spd[DATA_W-1] ? -$signed(tv_mag) : $signed(tv_mag);

    always_ff @(posedge clk)
    begin
        tf_reg       <= s2_reg.fneg ? -$signed(tf_mag) : $signed(tf_mag);
        tvpos_reg    <= PROD_W'(s2_reg.pos) + tv;
        spd_upd3_reg <= spd_upd2_reg;
        pos3_reg     <= s2_reg.pos;
        spd3_reg     <= s2_reg.spd;
    end

    // final position sum
    logic signed [PROD_W-1:0] pos_sum;
    lane_out_t                res_reg;

    assign pos_sum = tvpos_reg + tf_reg;

    always_ff @(posedge clk)
    begin
        res_reg.pos_upd  <= sat32(pos_sum);
        res_reg.spd_upd  <= spd_upd3_reg;
        res_reg.pos_pass <= pos3_reg;
        res_reg.spd_pass <= spd3_reg;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/velocity_verlet_particle_update_core.sv =====
// top level of the velocity verlet particle update core
// depends on vvpu_pkg and vvpu_lane (which uses vvpu_divider)
//
// usage
// - input items: drive the fields and raise start; an item is taken at a
//   clock edge with start high and busy low. busy is never raised, so one
//   particle may be taken every cycle
// - config: time_step (dt) is written over cfg_valid / cfg_ready / cfg_data;
//   cfg_ready is always high. write it only while no item is in flight
// - results: each item gives one result, shown for one cycle with done high;
//   done rises together with the registered outputs of the merging stage;
//   results keep input order
// - throughput: one item per cycle; latency is set by the 64-stage kick
//   divider, one quotient bit a stage, plus product and sum stages
// - three lanes handle x, y and z side by side; a merging stage applies the
//   phase command and the zero mass rule and raises zero_mass_error
// - the receiver cannot hold results off; nothing is buffered for it
// - reset clears the in-flight valid bits and sets dt to 1.0 (0x00010000)
`timescale 1ns / 1ps
`default_nettype none

module velocity_verlet_particle_update_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] position_x,
    input  logic [31:0] position_y,
    input  logic [31:0] position_z,
    input  logic [31:0] speed_x,
    input  logic [31:0] speed_y,
    input  logic [31:0] speed_z,
    input  logic [31:0] force_x,
    input  logic [31:0] force_y,
    input  logic [31:0] force_z,
    input  logic [31:0] mass,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] new_position_x,
    output logic [31:0] new_position_y,
    output logic [31:0] new_position_z,
    output logic [31:0] new_speed_x,
    output logic [31:0] new_speed_y,
    output logic [31:0] new_speed_z,
    output logic        zero_mass_error
);

    import vvpu_pkg::*;

    // fully pipelined, never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [DATA_W-1:0] time_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= DT_RESET;
        else if (cfg_valid && cfg_ready)
            time_step_reg <= cfg_data;
    end

    // input register
    logic              accept;
    ctl_t              in_ctl_reg;
    logic [DATA_W-1:0] in_pos_reg [LANES];
    logic [DATA_W-1:0] in_spd_reg [LANES];
    logic [DATA_W-1:0] in_frc_reg [LANES];
    logic [DATA_W-1:0] in_mass_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ctl_reg <= '0;
        else
        begin
            in_ctl_reg.valid <= accept;
            in_ctl_reg.cmd   <= command;
            in_ctl_reg.zero  <= (mass == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_pos_reg[0] <= position_x;
            in_pos_reg[1] <= position_y;
            in_pos_reg[2] <= position_z;
            in_spd_reg[0] <= speed_x;
            in_spd_reg[1] <= speed_y;
            in_spd_reg[2] <= speed_z;
            in_frc_reg[0] <= force_x;
            in_frc_reg[1] <= force_y;
            in_frc_reg[2] <= force_z;
            in_mass_reg   <= mass;
        end
    end

    // one lane per axis
    lane_out_t lane_res [LANES];

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            vvpu_lane #(
                .FRAC_BITS(FRAC_BITS)
            ) u_lane (
                .clk      (clk),
                .time_step(time_step_reg),
                .position (in_pos_reg[g]),
                .speed    (in_spd_reg[g]),
                .frc      (in_frc_reg[g]),
                .mass     (in_mass_reg),
                .result   (lane_res[g])
            );
        end
    endgenerate

    // control delay line matching the lane latency
    ctl_t ctl_reg [LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_LAT; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl_reg;
            for (int k = 1; k < LANE_LAT; k++)
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    // merging stage: phase select, zero mass rule, output register
    ctl_t              mctl;
    logic [DATA_W-1:0] pos_sel [LANES];
    logic [DATA_W-1:0] spd_sel [LANES];
    logic              done_reg;
    logic              err_reg;
    logic [DATA_W-1:0] pos_out_reg [LANES];
    logic [DATA_W-1:0] spd_out_reg [LANES];

    assign mctl = ctl_reg[LANE_LAT-1];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (mctl.zero)
            begin
                // no update when the mass is zero
                pos_sel[k] = lane_res[k].pos_pass;
                spd_sel[k] = lane_res[k].spd_pass;
            end
            else
            begin
                pos_sel[k] = mctl.cmd ? lane_res[k].pos_pass : lane_res[k].pos_upd;
                spd_sel[k] = lane_res[k].spd_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (mctl.valid)
        begin
            err_reg <= mctl.zero;
            for (int k = 0; k < LANES; k++)
            begin
                pos_out_reg[k] <= pos_sel[k];
                spd_out_reg[k] <= spd_sel[k];
            end
        end
    end

    assign done            = done_reg;
    assign zero_mass_error = err_reg;
    assign new_position_x  = pos_out_reg[0];
    assign new_position_y  = pos_out_reg[1];
    assign new_position_z  = pos_out_reg[2];
    assign new_speed_x     = spd_out_reg[0];
    assign new_speed_y     = spd_out_reg[1];
    assign new_speed_z     = spd_out_reg[2];

endmodule

`default_nettype wire
